### rtl/core/sgs_pkg.sv
// Shared types and constants for the slab geometry selector.
// Used by every module under rtl/core; depends on nothing.
package sgs_pkg;

    // Field and datapath widths
    localparam int OBJ_W   = 17;   // object size after marker and alignment
    localparam int REQ_W   = 16;   // raw request size
    localparam int HDR_W   = 12;   // slab header size
    localparam int MRK_W   = 8;    // trailing marker size
    localparam int PSH_W   = 5;    // page shift register
    localparam int P_W     = 18;   // page, two pages, single-object slab
    localparam int T_W     = 23;   // header + count * object
    localparam int CNT_W   = 7;    // object counts 0..65
    localparam int SLAB_W  = 24;   // slab and waste result width
    localparam int DATA_W  = 32;   // configuration data width
    localparam int ADDR_W  = 4;    // configuration byte address width

    localparam int MAX_OBJECTS    = 64;
    localparam int PAGE_SHIFT_MIN = 9;
    localparam int PAGE_SHIFT_MAX = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PAGE_SHIFT = 2'd0,
        REG_HEADER     = 2'd1,
        REG_MARKER     = 2'd2
    } t_reg_idx;

    // Decoded configuration shared by the front end and the cells
    typedef struct packed {
        logic [P_W-1:0]   page;
        logic [P_W-1:0]   page2;
        logic [HDR_W-1:0] header;
        logic [MRK_W-1:0] marker;
    } t_cfg;

    // Work travelling down the cell chain
    typedef struct packed {
        logic [OBJ_W-1:0] obj;       // aligned object size
        logic [T_W-1:0]   t;         // header + n * obj for the cell that gets it
        logic [CNT_W-1:0] n;         // count this cell evaluates
        logic [P_W-1:0]   cthr;      // slab for one object when nothing fits
        logic [P_W-1:0]   w_nf;      // waste of that slab
        logic             found;     // some count fits within two pages
        logic [CNT_W-1:0] best_n;    // best count so far
        logic [P_W-1:0]   best_w;    // its waste
        logic             best_dbl;  // its slab is two pages
        logic [CNT_W-1:0] cnt_a;     // counts whose layout fits one page
        logic [CNT_W-1:0] cnt_b;     // counts whose layout fits two pages
        logic [CNT_W-1:0] cnt_c;     // counts whose layout fits cthr
    } t_token;

endpackage

### rtl/core/sgs_cfg_regs.sv
// Configuration register file with an APB-style write and read port.
// Depends on sgs_pkg for widths, register indexes and the t_cfg type.
module sgs_cfg_regs
    import sgs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [PSH_W-1:0] r_page_shift;
    logic [HDR_W-1:0] r_header;
    logic [MRK_W-1:0] r_marker;
    logic             wr_en;
    t_reg_idx         reg_idx;
    logic [PSH_W-1:0] shift_clamp;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    // Write the addressed register at the end of the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= PSH_W'(12);
            r_header     <= HDR_W'(64);
            r_marker     <= MRK_W'(16);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAGE_SHIFT: r_page_shift <= pwdata[PSH_W-1:0];
                REG_HEADER:     r_header     <= pwdata[HDR_W-1:0];
                REG_MARKER:     r_marker     <= pwdata[MRK_W-1:0];
                default:        ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_PAGE_SHIFT: prdata = DATA_W'(r_page_shift);
            REG_HEADER:     prdata = DATA_W'(r_header);
            REG_MARKER:     prdata = DATA_W'(r_marker);
            default:        prdata = '0;
        endcase
    end

    // Clamp the page shift and decode page sizes
    always_comb begin
        if (r_page_shift < PSH_W'(PAGE_SHIFT_MIN)) begin
            shift_clamp = PSH_W'(PAGE_SHIFT_MIN);
        end else if (r_page_shift > PSH_W'(PAGE_SHIFT_MAX)) begin
            shift_clamp = PSH_W'(PAGE_SHIFT_MAX);
        end else begin
            shift_clamp = r_page_shift;
        end
        o_cfg.page   = P_W'(1) << shift_clamp;
        o_cfg.page2  = P_W'(2) << shift_clamp;
        o_cfg.header = r_header;
        o_cfg.marker = r_marker;
    end

endmodule

### rtl/core/sgs_front.sv
// Front end: object sizing, first layout, and the fallback single-object slab.
// Three register stages feeding the head of the cell chain; uses sgs_pkg.
module sgs_front
    import sgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [REQ_W-1:0] i_request_size,
    input  t_cfg             i_cfg,
    output logic             o_vld,
    output t_token           o_tok
);

    logic [OBJ_W-1:0] sum;
    logic [OBJ_W-1:0] obj;
    logic             r1_vld;
    logic [OBJ_W-1:0] r1_obj;
    logic             r2_vld;
    logic [OBJ_W-1:0] r2_obj;
    logic [OBJ_W-1:0] r2_t1;
    logic [OBJ_W-1:0] n2_t1;
    logic [OBJ_W-1:0] smear;
    logic [P_W-1:0]   cthr;
    logic             r3_vld;
    t_token           r3_tok;
    t_token           n3_tok;

    // Add the marker and align to 8 below 16 bytes, else to 16
    always_comb begin
        sum = OBJ_W'(i_request_size) + OBJ_W'(i_cfg.marker);
        if (sum < OBJ_W'(16)) begin
            obj = (sum + OBJ_W'(7)) & ~OBJ_W'(7);
        end else begin
            obj = (sum + OBJ_W'(15)) & ~OBJ_W'(15);
        end
    end

    // Layout size for a single object
    assign n2_t1 = OBJ_W'(i_cfg.header) + r1_obj;

    // Round the single-object layout to a power of two, at least one page
    always_comb begin
        smear = r2_t1 - OBJ_W'(1);
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        if (P_W'(r2_t1) <= i_cfg.page) begin
            cthr = i_cfg.page;
        end else begin
            cthr = P_W'(smear) + P_W'(1);
        end
        n3_tok          = '0;
        n3_tok.obj      = r2_obj;
        n3_tok.t        = T_W'(r2_t1);
        n3_tok.n        = CNT_W'(1);
        n3_tok.cthr     = cthr;
        n3_tok.w_nf     = cthr - P_W'(r2_t1);
        n3_tok.best_n   = CNT_W'(1);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r1_obj <= obj;
        r2_obj <= r1_obj;
        r2_t1  <= n2_t1;
        r3_tok <= n3_tok;
    end

    assign o_vld = r3_vld;
    assign o_tok = r3_tok;

endmodule

### rtl/core/sgs_cell.sv
// One cell of the count chain: scores one object count and keeps the best.
// Hands the token to the next cell every cycle; uses sgs_pkg.
module sgs_cell
    import sgs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_vld,
    input  t_token i_tok,
    output logic   o_vld,
    output t_token o_tok
);

    logic           fit_a;
    logic           fit_b;
    logic           fit_c;
    logic [P_W-1:0] slab;
    logic [P_W-1:0] waste;
    logic           better;
    logic           r_vld;
    t_token         r_tok;
    t_token         n_tok;

    // Score this count and fold it into the running best
    always_comb begin
        fit_a  = i_tok.t <= T_W'(i_cfg.page);
        fit_b  = i_tok.t <= T_W'(i_cfg.page2);
        fit_c  = i_tok.t <= T_W'(i_tok.cthr);
        slab   = fit_a ? i_cfg.page : i_cfg.page2;
        waste  = slab - i_tok.t[P_W-1:0];
        better = fit_b && (!i_tok.found || (waste < i_tok.best_w));

        n_tok       = i_tok;
        n_tok.t     = i_tok.t + T_W'(i_tok.obj);
        n_tok.n     = i_tok.n + CNT_W'(1);
        n_tok.cnt_a = i_tok.cnt_a + CNT_W'(fit_a);
        n_tok.cnt_b = i_tok.cnt_b + CNT_W'(fit_b);
        n_tok.cnt_c = i_tok.cnt_c + CNT_W'(fit_c);
        if (better) begin
            n_tok.found    = 1'b1;
            n_tok.best_n   = i_tok.n;
            n_tok.best_w   = waste;
            n_tok.best_dbl = !fit_a;
        end
    end

    // Advance valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

### rtl/core/slab_geometry_selector.sv
// Slab geometry selector top level: config port, front end, count chain, result stage.
// Depends on sgs_pkg, sgs_cfg_regs, sgs_front and sgs_cell.
//
// Usage:
//   Request channel: drive i_request_size with start high for one cycle.
//   busy is held low, so a request is taken in every cycle start is high.
//   Result channel: o_result_valid marks one cycle holding the object size,
//   chosen count, slab bytes, objects per slab, waste and oversize flag.
//   Pipeline: three front-end stages, one cell per object count (64),
//   one result stage.
//   Throughput is one request per cycle; requests never interact.
//   Results come back in request order and cannot be held off; the receiver
//   must take each one in the cycle it is shown.
//   Configuration: page_shift at byte 0, header_bytes at 4, marker_bytes at 8.
//   Write them only while no transaction is in flight.
//   Reset (synchronous, active low) clears all in-flight transactions and
//   restores page_shift 12, header_bytes 64, marker_bytes 16.
module slab_geometry_selector
    import sgs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    i_request_size,
    output logic                o_result_valid,
    output logic [OBJ_W-1:0]    o_object_bytes,
    output logic [CNT_W-1:0]    o_chosen_count,
    output logic [SLAB_W-1:0]   o_slab_bytes,
    output logic [CNT_W-1:0]    o_objects_per_slab,
    output logic [SLAB_W-1:0]   o_waste_bytes,
    output logic                o_oversize,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    t_cfg              cfg;
    logic              chain_vld [MAX_OBJECTS+1];
    t_token            chain_tok [MAX_OBJECTS+1];
    t_token            tail;
    logic [P_W-1:0]    slab;
    logic [P_W-1:0]    waste;
    logic [CNT_W-1:0]  per;
    logic              r_vld;
    logic [OBJ_W-1:0]  r_obj;
    logic [CNT_W-1:0]  r_count;
    logic [SLAB_W-1:0] r_slab;
    logic [CNT_W-1:0]  r_per;
    logic [SLAB_W-1:0] r_waste;
    logic              r_over;

    // The pipeline takes a transaction every cycle
    assign busy = 1'b0;

    sgs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sgs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (start & ~busy),
        .i_request_size (i_request_size),
        .i_cfg          (cfg),
        .o_vld          (chain_vld[0]),
        .o_tok          (chain_tok[0])
    );

    // One cell per object count
    for (genvar g = 0; g < MAX_OBJECTS; g++) begin : g_cell
        sgs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_vld   (chain_vld[g]),
            .i_tok   (chain_tok[g]),
            .o_vld   (chain_vld[g+1]),
            .o_tok   (chain_tok[g+1])
        );
    end

    // Select the slab of the winning count, or the single-object fallback
    always_comb begin
        tail = chain_tok[MAX_OBJECTS];
        if (tail.found) begin
            slab  = tail.best_dbl ? cfg.page2 : cfg.page;
            waste = tail.best_w;
            per   = tail.best_dbl ? tail.cnt_b : tail.cnt_a;
        end else begin
            slab  = tail.cthr;
            waste = tail.w_nf;
            per   = tail.cnt_c;
        end
    end

    // Hold the result strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= chain_vld[MAX_OBJECTS];
        end
    end

    // Register the result fields
    always_ff @(posedge i_clk) begin
        r_obj   <= tail.obj;
        r_count <= tail.best_n;
        r_slab  <= SLAB_W'(slab);
        r_per   <= per;
        r_waste <= SLAB_W'(waste);
        r_over  <= ~tail.found;
    end

    assign o_result_valid     = r_vld;
    assign o_object_bytes     = r_obj;
    assign o_chosen_count     = r_count;
    assign o_slab_bytes       = r_slab;
    assign o_objects_per_slab = r_per;
    assign o_waste_bytes      = r_waste;
    assign o_oversize         = r_over;

endmodule
